>>> hw/rtl/bcs_pkg.sv
// Package for the bounded composition stepper: sizes, payload structs, action codes
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bcs_pkg;

  localparam int SLOTS       = 8;
  localparam int COUNT_BITS  = 8;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NUM_W       = $clog2(SLOTS + 1);
  localparam int TOTAL_W     = 11;
  localparam int CFG_W       = 4;
  localparam int SUM_MIN_W   = COUNT_BITS + $clog2(SLOTS + 1);
  localparam int SUM_W       = (SUM_MIN_W > TOTAL_W) ? SUM_MIN_W : TOTAL_W;
  localparam int S_W         = SUM_W + 2;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 4'd8;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_FILL    = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  slot_select;
    logic [7:0]  limit_value;
    logic [10:0] total;
  } item_t;

  typedef struct packed {
    logic [2:0] slot_number;
    logic [7:0] slot_count;
    logic       ok;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_FILL_BEGIN,
    OP_SCAN_BEGIN,
    OP_FILL_STEP,
    OP_SCAN_STEP,
    OP_CLEAR_STEP,
    OP_EMIT_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   restart;
    logic   ok;
  } dp_cmd_t;

  typedef struct packed {
    logic k_last;
    logic k_zero;
    logic fill_last;
    logic hit;
    logic rem_zero;
  } dp_stat_t;

endpackage

>>> hw/rtl/bcs_ctrl.sv
// Controller of the bounded composition stepper: sequences the fill, odometer scan,
// clear and emit passes of the datapath. Depends on bcs_pkg.
`timescale 1ns / 1ps

module bcs_ctrl import bcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_CLEAR,
    S_EMIT
  } state_t;

  state_t state;
  logic   ok;
  logic   refill;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.op      = OP_NONE;
    cmd.restart = 1'b0;
    cmd.ok      = ok;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (action)
            ACT_LOAD:    cmd.op = OP_LOAD;
            ACT_FILL:    cmd.op = OP_FILL_BEGIN;
            ACT_ADVANCE: cmd.op = OP_SCAN_BEGIN;
            default:     cmd.op = OP_NONE;
          endcase
        end
      end
      S_FILL: begin
        cmd.op      = OP_FILL_STEP;
        cmd.restart = stat.fill_last;
      end
      S_SCAN: begin
        cmd.op      = OP_SCAN_STEP;
        cmd.restart = stat.k_last;
      end
      S_CLEAR: begin
        cmd.op      = OP_CLEAR_STEP;
        cmd.restart = stat.k_last;
      end
      S_EMIT: begin
        cmd.op      = OP_EMIT_STEP;
        cmd.restart = stat.k_last;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ok     <= 1'b0;
      refill <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (action == ACT_FILL) begin
              refill <= 1'b0;
              state  <= S_FILL;
            end else if (action == ACT_ADVANCE) begin
              state <= S_SCAN;
            end
          end
        end
        S_FILL: begin
          if (stat.fill_last) begin
            // A refill after an odometer step always succeeds.
            ok    <= refill | stat.rem_zero;
            state <= S_EMIT;
          end
        end
        S_SCAN: begin
          if (stat.hit) begin
            ok <= 1'b1;
            if (stat.k_zero) begin
              state <= S_EMIT;
            end else begin
              refill <= 1'b1;
              state  <= S_FILL;
            end
          end else if (stat.k_last) begin
            ok    <= 1'b0;
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (stat.k_last) state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.k_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/bcs_dp.sv
// Datapath of the bounded composition stepper: limit and count stores, slot counter,
// running sums, odometer step test and the result register. Depends on bcs_pkg.
`timescale 1ns / 1ps

module bcs_dp import bcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  input  item_t            item,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  output dp_stat_t         stat,
  output result_t          result,
  output logic             result_valid
);

  logic [COUNT_BITS-1:0] limit_store [SLOTS];
  logic [COUNT_BITS-1:0] count_store [SLOTS];
  logic [CFG_W-1:0]      slots_in_use;
  logic [IDX_W-1:0]      k;
  logic [IDX_W-1:0]      fill_top;
  logic [SUM_W-1:0]      amount;
  logic [SUM_W-1:0]      prefix;
  logic [SUM_W-1:0]      cap;

  logic [NUM_W-1:0]      n_eff;
  logic [IDX_W-1:0]      k_top;
  logic [COUNT_BITS-1:0] cnt_k;
  logic [COUNT_BITS-1:0] lim_k;
  logic [COUNT_BITS-1:0] fill_d;
  logic [SUM_W-1:0]      need;
  logic signed [S_W-1:0] need_s;
  logic signed [S_W-1:0] v_inc;
  logic signed [S_W-1:0] v_gap;
  logic signed [S_W-1:0] v;
  logic signed [S_W-1:0] rest;
  logic                  hit;
  logic                  sel_ok;

  always_comb begin
    if (slots_in_use == '0) begin
      n_eff = NUM_W'(1);
    end else if (int'(slots_in_use) > SLOTS) begin
      n_eff = NUM_W'(SLOTS);
    end else begin
      n_eff = NUM_W'(slots_in_use);
    end
  end

  assign k_top = IDX_W'(n_eff - NUM_W'(1));
  assign cnt_k = count_store[k];
  assign lim_k = limit_store[k];

  // Greedy share of the current slot.
  assign fill_d = (amount < SUM_W'(lim_k)) ? COUNT_BITS'(amount) : lim_k;

  // Odometer test: need is the sum of slots 0..k, cap the sum of limits below k.
  assign need   = prefix + SUM_W'(cnt_k);
  assign need_s = $signed(S_W'(need));
  assign v_inc  = $signed(S_W'(cnt_k)) + S_W'(1);
  assign v_gap  = need_s - $signed(S_W'(cap));
  assign v      = (v_gap > v_inc) ? v_gap : v_inc;
  assign hit    = (v <= $signed(S_W'(lim_k))) && (v <= need_s);
  assign rest   = need_s - v;

  assign sel_ok = int'(item.slot_select) < SLOTS;

  assign stat.k_last    = (k == k_top);
  assign stat.k_zero    = (k == '0);
  assign stat.fill_last = (k == fill_top);
  assign stat.hit       = hit;
  assign stat.rem_zero  = (amount == SUM_W'(fill_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RESET;
    end else if (cfg_write) begin
      slots_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        limit_store[i] <= '0;
        count_store[i] <= '0;
      end
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (cmd.op)
        OP_NONE: begin
        end
        OP_LOAD: begin
          if (sel_ok) limit_store[IDX_W'(item.slot_select)] <= COUNT_BITS'(item.limit_value);
          result.slot_number <= item.slot_select;
          result.slot_count  <= sel_ok ? 8'(COUNT_BITS'(item.limit_value)) : 8'd0;
          result.ok          <= sel_ok;
          result.last        <= 1'b1;
          result_valid       <= 1'b1;
        end
        OP_FILL_BEGIN: begin
          k        <= '0;
          amount   <= SUM_W'(item.total);
          fill_top <= k_top;
        end
        OP_SCAN_BEGIN: begin
          k      <= '0;
          prefix <= '0;
          cap    <= '0;
        end
        OP_FILL_STEP: begin
          count_store[k] <= fill_d;
          amount         <= amount - SUM_W'(fill_d);
          k              <= cmd.restart ? '0 : k + IDX_W'(1);
        end
        OP_SCAN_STEP: begin
          if (hit) begin
            // Slots below k are then refilled greedily with what is left.
            count_store[k] <= COUNT_BITS'(v);
            amount         <= SUM_W'(rest);
            fill_top       <= k - IDX_W'(1);
            k              <= '0;
          end else begin
            prefix <= need;
            cap    <= cap + SUM_W'(lim_k);
            k      <= cmd.restart ? '0 : k + IDX_W'(1);
          end
        end
        OP_CLEAR_STEP: begin
          count_store[k] <= '0;
          k              <= cmd.restart ? '0 : k + IDX_W'(1);
        end
        OP_EMIT_STEP: begin
          result.slot_number <= 3'(k);
          result.slot_count  <= 8'(cnt_k);
          result.ok          <= cmd.ok;
          result.last        <= stat.k_last;
          result_valid       <= 1'b1;
          k                  <= cmd.restart ? '0 : k + IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/bounded_composition_stepper_core.sv
// A load's word appears the cycle after start. With n active slots, fill runs a greedy
// pass, then emits one word per cycle; advance scans the odometer one slot per cycle, then
// refills the lower slots or clears all active slots and emits n words.
// The next start is taken at the edge that retires the last word; results never stall.
// Reset (rst, synchronous) zeroes all limits and counts and sets slots_in_use to 8.
// Top level; depends on bcs_pkg, bcs_ctrl and bcs_dp.
`timescale 1ns / 1ps

module bounded_composition_stepper_core import bcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  output result_t          result,
  output logic             result_valid,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // A configuration word is held off while the core is busy or an item is being accepted.
  assign cfg_ready = ~busy & ~start;

  bcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  bcs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .cfg_write    (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
